// File: hw/rtl/rational_arithmetic_unit_assert.svh
// Assertion macros for the rational arithmetic unit.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH

// ante holds in a cycle -> cons holds in the same cycle
`define RAU_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante holds in a cycle -> cons holds in the next cycle
`define RAU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/rau_pkg.sv
// Package for the rational arithmetic unit: widths, codes, payload and link types.
// No dependencies.
package rau_pkg;

    localparam int OPERAND_WIDTH = 32;
    localparam int FIELD_WIDTH   = 32;
    localparam int PROD_WIDTH    = 2 * OPERAND_WIDTH;
    localparam int RES_WIDTH     = 64;
    localparam int DIV_CNT_W     = $clog2(RES_WIDTH);

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_MUL    = 3'd1;
    localparam logic [2:0] OP_LT     = 3'd2;
    localparam logic [2:0] OP_EQ     = 3'd3;
    localparam logic [2:0] OP_REDUCE = 3'd4;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_ZERO_GCD = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [2:0]                    operation;
        logic signed [FIELD_WIDTH-1:0] a_numerator;
        logic signed [FIELD_WIDTH-1:0] a_denominator;
        logic signed [FIELD_WIDTH-1:0] b_numerator;
        logic signed [FIELD_WIDTH-1:0] b_denominator;
    } rau_in_t;

    typedef struct packed {
        logic signed [RES_WIDTH-1:0] result_numerator;
        logic signed [RES_WIDTH-1:0] result_denominator;
        logic                        compare_true;
        logic [1:0]                  status;
    } rau_out_t;

    typedef struct packed {
        logic                 start;
        logic [RES_WIDTH-1:0] dividend;
        logic [RES_WIDTH-1:0] divisor;
    } rau_div_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [RES_WIDTH-1:0] quotient;
        logic [RES_WIDTH-1:0] remainder;
    } rau_div_rsp_t;

    function automatic logic [RES_WIDTH-1:0] mag_of(input logic [RES_WIDTH-1:0] x);
        return x[RES_WIDTH-1] ? (RES_WIDTH'(0) - x) : x;
    endfunction

endpackage

// File: hw/rtl/rau_div.sv
// Shift-subtract unsigned divider, one quotient bit per cycle.
// Depends on rau_pkg and rational_arithmetic_unit_assert.svh.
`include "rational_arithmetic_unit_assert.svh"

module rau_div
    import rau_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  rau_div_req_t req,
    output rau_div_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [RES_WIDTH-1:0] quo_reg, quo_next;
    logic [RES_WIDTH-1:0] rem_reg, rem_next;
    logic [RES_WIDTH-1:0] dvs_reg, dvs_next;
    logic [RES_WIDTH:0]   trial;
    logic [RES_WIDTH:0]   diff;
    logic                 ge;

    assign trial = {rem_reg, quo_reg[RES_WIDTH-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[RES_WIDTH-2:0], ge};
            rem_next = ge ? diff[RES_WIDTH-1:0] : trial[RES_WIDTH-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(RES_WIDTH - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

    `RAU_ASSERT_IMPLY(a_no_start_busy, req.start, !busy_reg, "divider started while busy")
    `RAU_ASSERT_IMPLY(a_done_idle, done_reg, !busy_reg, "divider done while still busy")
    `RAU_ASSERT_IMPLY(a_rem_below, done_reg, rem_reg < dvs_reg, "remainder not below divisor")

endmodule

// File: hw/rtl/rau_seq.sv
// Sequencer: shared multiplier for cross products, Euclid gcd and reduction on rau_div.
// Depends on rau_pkg, rau_div and rational_arithmetic_unit_assert.svh.
`include "rational_arithmetic_unit_assert.svh"

module rau_seq
    import rau_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  rau_in_t  item,
    output logic     idle,
    output logic     res_valid,
    input  logic     res_ready,
    output rau_out_t res
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MUL  = 8'b0000_0010,
        S_FORM = 8'b0000_0100,
        S_GCD  = 8'b0000_1000,
        S_GCDW = 8'b0001_0000,
        S_QNW  = 8'b0010_0000,
        S_QDW  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } state_t;

    localparam logic [1:0] STEP_LAST_ADD   = 2'd2;
    localparam logic [1:0] STEP_LAST_OTHER = 2'd1;

    state_t state_reg, state_next;
    logic [2:0]                      op_reg, op_next;
    logic [1:0]                      step_reg, step_next;
    logic signed [OPERAND_WIDTH-1:0] an_reg, an_next, ad_reg, ad_next;
    logic signed [OPERAND_WIDTH-1:0] bn_reg, bn_next, bd_reg, bd_next;
    logic signed [RES_WIDTH-1:0]     p0_reg, p0_next, p1_reg, p1_next, p2_reg, p2_next;
    logic [RES_WIDTH-1:0]            n_reg, n_next, d_reg, d_next;
    logic [RES_WIDTH-1:0]            ga_reg, ga_next, gb_reg, gb_next;
    logic [RES_WIDTH-1:0]            rn_reg, rn_next, rd_reg, rd_next;
    logic                            cmp_reg, cmp_next;
    logic [1:0]                      status_reg, status_next;
    logic                            ovf_reg, ovf_next;

    logic signed [OPERAND_WIDTH-1:0] mul_x, mul_y;
    logic signed [PROD_WIDTH-1:0]    mul_prod;
    logic signed [RES_WIDTH-1:0]     prod_ext;
    logic signed [RES_WIDTH-1:0]     sum;
    logic                            add_ovf;
    logic [1:0]                      step_last;
    logic [RES_WIDTH-1:0]            q_signed;
    logic                            q_ovf;
    logic [RES_WIDTH-1:0]            quo_dividend;

    rau_div_req_t div_req;
    rau_div_rsp_t div_rsp;

    rau_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        mul_x = an_reg;
        mul_y = bd_reg;
        priority if (op_reg == OP_ADD)
        begin
            unique case (step_reg)
                2'd0:    begin mul_x = bd_reg; mul_y = an_reg; end
                2'd1:    begin mul_x = ad_reg; mul_y = bn_reg; end
                default: begin mul_x = ad_reg; mul_y = bd_reg; end
            endcase
        end
        else if (op_reg == OP_MUL)
        begin
            if (step_reg == 2'd0)
            begin
                mul_x = an_reg;
                mul_y = bn_reg;
            end
            else
            begin
                mul_x = ad_reg;
                mul_y = bd_reg;
            end
        end
        else
        begin
            if (step_reg == 2'd0)
            begin
                mul_x = an_reg;
                mul_y = bd_reg;
            end
            else
            begin
                mul_x = ad_reg;
                mul_y = bn_reg;
            end
        end
    end

    assign mul_prod  = mul_x * mul_y;
    assign prod_ext  = RES_WIDTH'(mul_prod);
    assign sum       = p0_reg + p1_reg;
    assign add_ovf   = (p0_reg[RES_WIDTH-1] == p1_reg[RES_WIDTH-1])
                       && (sum[RES_WIDTH-1] != p0_reg[RES_WIDTH-1]);
    assign step_last = (op_reg == OP_ADD) ? STEP_LAST_ADD : STEP_LAST_OTHER;

    // Sign the quotient of the dividend in flight by the gcd held in ga_reg.
    assign quo_dividend = state_reg == S_QNW ? n_reg : d_reg;
    assign q_signed = (quo_dividend[RES_WIDTH-1] != ga_reg[RES_WIDTH-1])
                      ? (RES_WIDTH'(0) - div_rsp.quotient) : div_rsp.quotient;
    assign q_ovf    = (quo_dividend[RES_WIDTH-1] == ga_reg[RES_WIDTH-1])
                      && (div_rsp.quotient == {1'b1, {(RES_WIDTH-1){1'b0}}});

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        step_next   = step_reg;
        an_next     = an_reg;
        ad_next     = ad_reg;
        bn_next     = bn_reg;
        bd_next     = bd_reg;
        p0_next     = p0_reg;
        p1_next     = p1_reg;
        p2_next     = p2_reg;
        n_next      = n_reg;
        d_next      = d_reg;
        ga_next     = ga_reg;
        gb_next     = gb_reg;
        rn_next     = rn_reg;
        rd_next     = rd_reg;
        cmp_next    = cmp_reg;
        status_next = status_reg;
        ovf_next    = ovf_reg;
        div_req     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next     = item.operation;
                    an_next     = item.a_numerator[OPERAND_WIDTH-1:0];
                    ad_next     = item.a_denominator[OPERAND_WIDTH-1:0];
                    bn_next     = item.b_numerator[OPERAND_WIDTH-1:0];
                    bd_next     = item.b_denominator[OPERAND_WIDTH-1:0];
                    step_next   = '0;
                    rn_next     = '0;
                    rd_next     = '0;
                    cmp_next    = 1'b0;
                    status_next = STATUS_OK;
                    ovf_next    = 1'b0;
                    if (item.operation == OP_ADD || item.operation == OP_MUL
                        || item.operation == OP_LT)
                        state_next = S_MUL;
                    else
                        state_next = S_FORM;
                end
            end
            S_MUL:
            begin
                unique case (step_reg)
                    2'd0:    p0_next = prod_ext;
                    2'd1:    p1_next = prod_ext;
                    default: p2_next = prod_ext;
                endcase
                step_next = step_reg + 1'b1;
                if (step_reg == step_last)
                    state_next = S_FORM;
            end
            S_FORM:
            begin
                state_next = S_GCD;
                unique case (op_reg)
                    OP_ADD:
                    begin
                        n_next  = sum;
                        d_next  = p2_reg;
                        ga_next = sum;
                        gb_next = p2_reg;
                        if (add_ovf)
                        begin
                            status_next = STATUS_OVERFLOW;
                            state_next  = S_DONE;
                        end
                    end
                    OP_MUL:
                    begin
                        n_next  = p0_reg;
                        d_next  = p1_reg;
                        ga_next = p0_reg;
                        gb_next = p1_reg;
                    end
                    OP_LT:
                    begin
                        cmp_next   = p0_reg < p1_reg;
                        state_next = S_DONE;
                    end
                    OP_EQ:
                    begin
                        cmp_next   = (an_reg == bn_reg) && (ad_reg == bd_reg);
                        state_next = S_DONE;
                    end
                    OP_REDUCE:
                    begin
                        n_next  = RES_WIDTH'(an_reg);
                        d_next  = RES_WIDTH'(ad_reg);
                        ga_next = RES_WIDTH'(an_reg);
                        gb_next = RES_WIDTH'(ad_reg);
                    end
                    default:
                        state_next = S_DONE;
                endcase
            end
            S_GCD:
            begin
                if (gb_reg == '0)
                begin
                    if (ga_reg == '0)
                    begin
                        status_next = STATUS_ZERO_GCD;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = mag_of(n_reg);
                        div_req.divisor  = mag_of(ga_reg);
                        state_next       = S_QNW;
                    end
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = mag_of(ga_reg);
                    div_req.divisor  = mag_of(gb_reg);
                    state_next       = S_GCDW;
                end
            end
            S_GCDW:
            begin
                if (div_rsp.done)
                begin
                    ga_next    = gb_reg;
                    gb_next    = ga_reg[RES_WIDTH-1]
                                 ? (RES_WIDTH'(0) - div_rsp.remainder) : div_rsp.remainder;
                    state_next = S_GCD;
                end
            end
            S_QNW:
            begin
                if (div_rsp.done)
                begin
                    rn_next          = q_signed;
                    ovf_next         = q_ovf;
                    div_req.start    = 1'b1;
                    div_req.dividend = mag_of(d_reg);
                    div_req.divisor  = mag_of(ga_reg);
                    state_next       = S_QDW;
                end
            end
            S_QDW:
            begin
                if (div_rsp.done)
                begin
                    if (ovf_reg || q_ovf)
                    begin
                        rn_next     = '0;
                        rd_next     = '0;
                        status_next = STATUS_OVERFLOW;
                    end
                    else
                        rd_next = q_signed;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        step_reg   <= step_next;
        an_reg     <= an_next;
        ad_reg     <= ad_next;
        bn_reg     <= bn_next;
        bd_reg     <= bd_next;
        p0_reg     <= p0_next;
        p1_reg     <= p1_next;
        p2_reg     <= p2_next;
        n_reg      <= n_next;
        d_reg      <= d_next;
        ga_reg     <= ga_next;
        gb_reg     <= gb_next;
        rn_reg     <= rn_next;
        rd_reg     <= rd_next;
        cmp_reg    <= cmp_next;
        status_reg <= status_next;
        ovf_reg    <= ovf_next;
    end

    assign idle                   = state_reg == S_IDLE;
    assign res_valid              = state_reg == S_DONE;
    assign res.result_numerator   = rn_reg;
    assign res.result_denominator = rd_reg;
    assign res.compare_true       = cmp_reg;
    assign res.status             = status_reg;

    `RAU_ASSERT_IMPLY(a_idle_div_quiet, state_reg == S_IDLE, !div_rsp.busy,
                      "divider busy while sequencer idle")
    `RAU_ASSERT_IMPLY(a_err_zero_fields,
                      res_valid && (status_reg == STATUS_ZERO_GCD || status_reg == STATUS_OVERFLOW),
                      rn_reg == '0 && rd_reg == '0 && !cmp_reg,
                      "error result carries nonzero fields")
    `RAU_ASSERT_NEXT(a_done_leaves, res_valid && res_ready, state_reg == S_IDLE,
                     "sequencer did not return to idle after result taken")

endmodule

// File: hw/rtl/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit: input handshake and output register.
// Depends on rau_pkg and rau_seq.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+---------------------
//   in       | in_valid / in_ready      | in_item  (rau_in_t)
//   out      | out_valid / out_ready    | out_item (rau_out_t)
//
// Less-than, equal and unused codes end without the divider; add, multiply and reduce
// run one divide per Euclid remainder step plus the zero check and two final divides
// on the shared 64-bit shift-subtract divider; an add that overflows ends early.
// One transaction in flight; in_ready is low from accept until the result enters
// the output register. Reset clears the sequencer and output valid; out_ready
// low holds the result and stalls the sequencer in its done state.
module rational_arithmetic_unit
    import rau_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  rau_in_t  in_item,
    output logic     out_valid,
    input  logic     out_ready,
    output rau_out_t out_item
);

    logic     seq_idle;
    logic     seq_valid;
    logic     seq_ready;
    rau_out_t seq_res;
    logic     out_valid_reg, out_valid_next;
    rau_out_t out_item_reg, out_item_next;

    rau_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_valid && seq_idle),
        .item      (in_item),
        .idle      (seq_idle),
        .res_valid (seq_valid),
        .res_ready (seq_ready),
        .res       (seq_res)
    );

    assign seq_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (seq_valid && seq_ready)
        begin
            out_valid_next = 1'b1;
            out_item_next  = seq_res;
        end
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign in_ready  = seq_idle;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for rational_arithmetic_unit: directed and random fraction traffic.
// Depends on rau_pkg and the RTL; predicts each result with its own gcd reduction model.
`timescale 1ns / 100ps

module tb_top;
    import rau_pkg::*;

    typedef logic [RES_WIDTH-1:0] wide_t;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int END_HOLDOFF    = 200;
    localparam int MAX_REPORTS    = 10;

    localparam logic [2:0] OP_LAST_CODE = 3'd7;

    localparam logic signed [FIELD_WIDTH-1:0] FIELD_MAX = {1'b0, {(FIELD_WIDTH-1){1'b1}}};
    localparam logic signed [FIELD_WIDTH-1:0] FIELD_MIN = {1'b1, {(FIELD_WIDTH-1){1'b0}}};
    localparam logic signed [FIELD_WIDTH-1:0] FIELD_ONE = FIELD_WIDTH'(1);
    localparam logic signed [FIELD_WIDTH-1:0] FIELD_NEG = '1;
    localparam logic signed [FIELD_WIDTH-1:0] FIELD_ZERO = '0;

    localparam wide_t WIDE_MIN = {1'b1, {(RES_WIDTH-1){1'b0}}};

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_ready;
    rau_in_t  in_item = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    rau_out_t out_item;

    rau_out_t expected_results[$];
    rau_out_t oldest_expected;
    int       stall_pct = 0;
    int       mismatch_count = 0;
    int       results_seen = 0;
    int       quiet_cycles = 0;

    rational_arithmetic_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic wide_t widen(input logic [FIELD_WIDTH-1:0] v);
        return {{(RES_WIDTH-OPERAND_WIDTH){v[OPERAND_WIDTH-1]}}, v[OPERAND_WIDTH-1:0]};
    endfunction

    function automatic wide_t magnitude(input wide_t x);
        return x[RES_WIDTH-1] ? (wide_t'(0) - x) : x;
    endfunction

    function automatic wide_t trunc_rem(input wide_t a, input wide_t b);
        wide_t r;
        r = magnitude(a) % magnitude(b);
        return a[RES_WIDTH-1] ? (wide_t'(0) - r) : r;
    endfunction

    function automatic wide_t trunc_quot(input wide_t a, input wide_t b);
        wide_t q;
        q = magnitude(a) / magnitude(b);
        return (a[RES_WIDTH-1] != b[RES_WIDTH-1]) ? (wide_t'(0) - q) : q;
    endfunction

    function automatic bit quot_overflows(input wide_t a, input wide_t b);
        return (a[RES_WIDTH-1] == b[RES_WIDTH-1])
            && ((magnitude(a) / magnitude(b)) == WIDE_MIN);
    endfunction

    function automatic rau_out_t reduce_fraction(input wide_t n, input wide_t d);
        rau_out_t r;
        wide_t    g;
        wide_t    t;
        wide_t    hold;
        r = '0;
        g = n;
        t = d;
        while (t != '0)
        begin
            hold = t;
            t = trunc_rem(g, t);
            g = hold;
        end
        if (g == '0)
            r.status = STATUS_ZERO_GCD;
        else if (quot_overflows(n, g) || quot_overflows(d, g))
            r.status = STATUS_OVERFLOW;
        else
        begin
            r.result_numerator   = trunc_quot(n, g);
            r.result_denominator = trunc_quot(d, g);
            r.status             = STATUS_OK;
        end
        return r;
    endfunction

    function automatic rau_out_t predict_result(input rau_in_t x);
        rau_out_t r;
        wide_t    an;
        wide_t    ad;
        wide_t    bn;
        wide_t    bd;
        wide_t    p;
        wide_t    q;
        wide_t    s;
        r  = '0;
        an = widen(x.a_numerator);
        ad = widen(x.a_denominator);
        bn = widen(x.b_numerator);
        bd = widen(x.b_denominator);
        case (x.operation)
            OP_ADD:
            begin
                p = bd * an;
                q = ad * bn;
                s = p + q;
                if (p[RES_WIDTH-1] == q[RES_WIDTH-1] && s[RES_WIDTH-1] != p[RES_WIDTH-1])
                    r.status = STATUS_OVERFLOW;
                else
                    r = reduce_fraction(s, ad * bd);
            end
            OP_MUL:
                r = reduce_fraction(an * bn, ad * bd);
            OP_LT:
            begin
                p = an * bd;
                q = ad * bn;
                r.compare_true = ($signed(p) < $signed(q));
            end
            OP_EQ:
                r.compare_true = (an == bn) && (ad == bd);
            OP_REDUCE:
                r = reduce_fraction(an, ad);
            default:
                r = '0;
        endcase
        return r;
    endfunction

    function automatic rau_in_t make_item(input logic [2:0] op,
                                          input logic [FIELD_WIDTH-1:0] an,
                                          input logic [FIELD_WIDTH-1:0] ad,
                                          input logic [FIELD_WIDTH-1:0] bn,
                                          input logic [FIELD_WIDTH-1:0] bd);
        rau_in_t x;
        x.operation     = op;
        x.a_numerator   = an;
        x.a_denominator = ad;
        x.b_numerator   = bn;
        x.b_denominator = bd;
        return x;
    endfunction

    function automatic logic [FIELD_WIDTH-1:0] random_operand();
        int pick;
        pick = $urandom_range(9);
        case (pick)
            0, 1, 2: return FIELD_WIDTH'($urandom);
            3, 4, 5: return FIELD_WIDTH'(int'($urandom_range(32)) - 16);
            6:
            begin
                case ($urandom_range(4))
                    0: return FIELD_ZERO;
                    1: return FIELD_ONE;
                    2: return FIELD_NEG;
                    3: return FIELD_MAX;
                    default: return FIELD_MIN;
                endcase
            end
            7: return FIELD_WIDTH'(int'($urandom_range(65535)) - 32768);
            default:
                return FIELD_WIDTH'((int'($urandom_range(200)) - 100)
                                    * int'($urandom_range(1, 1000)));
        endcase
    endfunction

    function automatic rau_in_t random_item();
        rau_in_t x;
        int      k;
        k = $urandom_range(99);
        x = make_item(OP_ADD, random_operand(), random_operand(),
                      random_operand(), random_operand());
        if (k < 25)
            x.operation = OP_ADD;
        else if (k < 50)
            x.operation = OP_MUL;
        else if (k < 65)
            x.operation = OP_LT;
        else if (k < 80)
            x.operation = OP_EQ;
        else if (k < 95)
            x.operation = OP_REDUCE;
        else
            x.operation = 3'($urandom_range(OP_REDUCE + 1, OP_LAST_CODE));
        if (x.operation == OP_EQ && $urandom_range(1) == 1)
        begin
            x.b_numerator   = x.a_numerator;
            x.b_denominator = x.a_denominator;
        end
        return x;
    endfunction

    task automatic send_fractions(input rau_in_t x);
        in_valid <= 1'b1;
        in_item  <= x;
        do
            @(posedge clk);
        while (!in_ready);
        expected_results.push_back(predict_result(x));
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    task automatic test_field_extremes();
        send_fractions(make_item(OP_ADD, FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX));
        send_fractions(make_item(OP_MUL, FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN));
        send_fractions(make_item(OP_MUL, FIELD_MAX, FIELD_MIN, FIELD_MIN, FIELD_MAX));
        send_fractions(make_item(OP_LT, FIELD_MIN, FIELD_MAX, FIELD_MAX, FIELD_MIN));
        send_fractions(make_item(OP_LT, FIELD_MAX, FIELD_NEG, FIELD_MIN, FIELD_ONE));
        send_fractions(make_item(OP_EQ, FIELD_MIN, FIELD_MAX, FIELD_MIN, FIELD_MAX));
        send_fractions(make_item(OP_REDUCE, FIELD_MIN, FIELD_MAX, FIELD_ZERO, FIELD_ZERO));
        send_fractions(make_item(OP_REDUCE, FIELD_MIN, FIELD_NEG, FIELD_NEG, FIELD_NEG));
        wait_for_drain();
    endtask

    task automatic test_each_operation();
        send_fractions(make_item(OP_ADD, 32'sd1, 32'sd2, 32'sd1, 32'sd3));
        send_fractions(make_item(OP_ADD, -32'sd3, 32'sd4, 32'sd1, -32'sd4));
        send_fractions(make_item(OP_MUL, 32'sd6, -32'sd9, 32'sd3, 32'sd4));
        send_fractions(make_item(OP_LT, 32'sd1, 32'sd3, 32'sd1, 32'sd2));
        send_fractions(make_item(OP_LT, 32'sd1, 32'sd2, 32'sd1, 32'sd3));
        send_fractions(make_item(OP_EQ, 32'sd2, 32'sd4, 32'sd1, 32'sd2));
        send_fractions(make_item(OP_REDUCE, 32'sd6, -32'sd4, 32'sd0, 32'sd0));
        wait_for_drain();
    endtask

    task automatic test_status_codes();
        send_fractions(make_item(OP_REDUCE, FIELD_ZERO, FIELD_ZERO, 32'sd5, 32'sd7));
        send_fractions(make_item(OP_MUL, FIELD_ZERO, 32'sd5, 32'sd7, FIELD_ZERO));
        send_fractions(make_item(OP_ADD, FIELD_ZERO, FIELD_ZERO, FIELD_ZERO, FIELD_ZERO));
        send_fractions(make_item(OP_ADD, FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN));
        send_fractions(make_item(OP_ADD, FIELD_MIN, FIELD_MAX, FIELD_MIN, FIELD_MAX));
        send_fractions(make_item(OP_REDUCE, -32'sd5, FIELD_ZERO, FIELD_ZERO, FIELD_ZERO));
        wait_for_drain();
    endtask

    task automatic test_unused_codes();
        logic [2:0] op;
        for (op = OP_REDUCE + 3'd1; op != OP_ADD; op++)
            send_fractions(make_item(op, random_operand(), random_operand(),
                                     random_operand(), random_operand()));
        wait_for_drain();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall, input int count);
        stall_pct = stall;
        repeat (count)
        begin
            while ($urandom_range(99) < idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            send_fractions(random_item());
            if ($urandom_range(199) == 0)
                wait_for_drain();
        end
        wait_for_drain();
    endtask

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result %0d: num %0d den %0d cmp %0b st %0d",
                             results_seen, out_item.result_numerator,
                             out_item.result_denominator, out_item.compare_true,
                             out_item.status);
            end
            else
            begin
                oldest_expected = expected_results.pop_front();
                if (out_item.result_numerator !== oldest_expected.result_numerator
                    || out_item.result_denominator !== oldest_expected.result_denominator
                    || out_item.compare_true !== oldest_expected.compare_true
                    || out_item.status !== oldest_expected.status)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("result %0d: expected num %0d den %0d cmp %0b st %0d",
                                 results_seen, oldest_expected.result_numerator,
                                 oldest_expected.result_denominator,
                                 oldest_expected.compare_true, oldest_expected.status);
                        $display("result %0d: got num %0d den %0d cmp %0b st %0d",
                                 results_seen, out_item.result_numerator,
                                 out_item.result_denominator,
                                 out_item.compare_true, out_item.status);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_field_extremes();
        test_each_operation();
        test_status_codes();
        test_unused_codes();
        test_random_traffic(0, 0, 350);
        test_random_traffic(55, 0, 350);
        test_random_traffic(0, 55, 350);
        test_random_traffic(12, 12, 350);
        repeat (END_HOLDOFF) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/rau_pkg.sv
hw/rtl/rau_div.sv
hw/rtl/rau_seq.sv
hw/rtl/rational_arithmetic_unit.sv
dv/tb_top.sv
